// ----- design/lzwd_pkg.sv -----
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared types and constants for the LZ word decompressor: op codes, parse
// phases, status codes and the per-request result record.
// ----------------------------------------------------------------------------
package lzwd_pkg;

    localparam int WORD_W     = 16;
    localparam int OFFSET_W   = 11;
    localparam int LEN_W      = WORD_W - OFFSET_W;
    localparam int FLAG_CNT_W = 5;

    // items carried under one flag word
    localparam logic [FLAG_CNT_W-1:0] FLAG_ITEMS = 5'd16;

    // request op codes, the unused code changes no state and emits no word
    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_TICK    = 2'd1,
        OP_RESTART = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        PH_FLAG = 2'd0,
        PH_ITEM = 2'd1,
        PH_LEN  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_END        = 2'd1,
        ST_BAD_OFFSET = 2'd2,
        ST_REFUSED    = 2'd3
    } status_t;

    // result of one request as seen by the output pipeline
    typedef struct packed {
        logic              emit;
        logic              src_mem;
        logic [WORD_W-1:0] data;
        logic              copy_pending;
        status_t           status;
    } lzwd_item_t;

endpackage

// ----- design/lz_word_decompressor.sv -----
// ----------------------------------------------------------------------------
// lz_word_decompressor
// LZ decompressor for a stream of 16-bit words with a history window.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: each request carries an op in s_tuser (push a
//   compressed word, tick to emit the next copy word, restart) and the
//   compressed word in s_tdata. Output channel m_*: exactly one result per
//   request, in request order, with the decompressed word, a valid flag,
//   the copy-pending flag and the status code.
//   A request passes the input register, the history read stage and the
//   result register to m_*. Throughput: one request per cycle while
//   m_tready is high, including back-to-back ticks of an overlapping copy;
//   a copy that reads the word written by the previous request is served by
//   forwarding around the history memory, whose read data is registered.
//   Reset: parser state, copy count and window fill count are cleared, the
//   pipeline empties; the history memory is not cleared, since no offset
//   that passes the check can reach an unwritten entry.
//   Stall: while m_tready is low the result register holds, and the input
//   register plus one internal stage absorb two further requests before
//   s_tready drops.
// ----------------------------------------------------------------------------
module lz_word_decompressor
    import lzwd_pkg::*;
#(
    parameter int WINDOW_WORDS = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // in_word
    input  logic [1:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // out_valid, out_word, copy_pending, status, zero pad
);

    localparam int AW = $clog2(WINDOW_WORDS);

    // input register
    logic              s1_valid_reg;
    op_t               s1_op_reg;
    logic [WORD_W-1:0] s1_word_reg;

    // history read stage
    logic              s2_valid_reg;
    logic              s2_emit_reg;
    logic              s2_from_mem_reg, s2_from_mem_next;
    logic [WORD_W-1:0] s2_data_reg, s2_data_next;
    logic              s2_pending_reg;
    status_t           s2_status_reg;
    logic [AW-1:0]     s2_wr_addr_reg;

    // result register
    logic              out_valid_reg;
    logic              out_emit_reg;
    logic [WORD_W-1:0] out_word_reg;
    logic              out_pending_reg;
    status_t           out_status_reg;

    logic              s1_fire;
    logic              s2_fire;
    logic              fwd_hit;
    logic [WORD_W-1:0] s2_word;
    logic [WORD_W-1:0] rd_data;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    lzwd_item_t        item;

    // pipeline flow control
    assign s2_fire  = s2_valid_reg && (!out_valid_reg || m_tready);
    assign s1_fire  = s1_valid_reg && (!s2_valid_reg || s2_fire);
    assign s_tready = !s1_valid_reg || s1_fire;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_op_reg   <= op_t'(s_tuser);
            s1_word_reg <= s_tdata;
        end
    end

    lzwd_parser #(
        .WINDOW_WORDS (WINDOW_WORDS),
        .AW           (AW)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (s1_fire),
        .op      (s1_op_reg),
        .word    (s1_word_reg),
        .item    (item),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr)
    );

    // word leaving the read stage, also the history write data
    assign s2_word = s2_from_mem_reg ? rd_data : s2_data_reg;

    // forward the word being written when the copy reads that same entry
    assign fwd_hit = item.src_mem && s2_valid_reg && s2_emit_reg
                     && (s2_wr_addr_reg == rd_addr);

    always_comb
    begin
        s2_from_mem_next = item.src_mem && !fwd_hit;
        s2_data_next     = fwd_hit ? s2_word : item.data;
    end

    // memory spans the full address range so the pointer wraps cleanly
    lzwd_history #(
        .DEPTH (2 ** AW),
        .AW    (AW)
    ) u_history (
        .clk     (clk),
        .wr_en   (s2_fire && s2_emit_reg),
        .wr_addr (s2_wr_addr_reg),
        .wr_data (s2_word),
        .rd_en   (s1_fire && s2_from_mem_next),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // history read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (!s2_valid_reg || s2_fire)
        begin
            s2_valid_reg <= s1_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            s2_emit_reg     <= item.emit;
            s2_from_mem_reg <= s2_from_mem_next;
            s2_data_reg     <= s2_data_next;
            s2_pending_reg  <= item.copy_pending;
            s2_status_reg   <= item.status;
            s2_wr_addr_reg  <= wr_addr;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            out_emit_reg    <= s2_emit_reg;
            out_word_reg    <= s2_emit_reg ? s2_word : '0;
            out_pending_reg <= s2_pending_reg;
            out_status_reg  <= s2_status_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_status_reg, out_pending_reg, out_word_reg, out_emit_reg};

endmodule

// ----- design/lzwd_history.sv -----
// ----------------------------------------------------------------------------
// lzwd_history
// History window memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lzwd_history #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic [lzwd_pkg::WORD_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [AW-1:0]            rd_addr,
    output logic [lzwd_pkg::WORD_W-1:0] rd_data
);

    logic [lzwd_pkg::WORD_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- design/lzwd_parser.sv -----
// ----------------------------------------------------------------------------
// lzwd_parser
// Stream parser state and next-state logic: flag word handling, literal and
// match decoding, copy counting and window bookkeeping for one request.
// ----------------------------------------------------------------------------
module lzwd_parser
    import lzwd_pkg::*;
#(
    parameter int WINDOW_WORDS = 2048,
    parameter int AW           = 11
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  op_t               op,
    input  logic [WORD_W-1:0] word,
    output lzwd_item_t        item,
    output logic [AW-1:0]     rd_addr,
    output logic [AW-1:0]     wr_addr
);

    localparam int          AW1     = AW + 1;
    localparam logic [AW:0] WW_FULL = AW1'(WINDOW_WORDS);

    phase_t                phase_reg, phase_next;
    logic [WORD_W-1:0]     flag_reg, flag_next;
    logic [FLAG_CNT_W-1:0] pos_reg, pos_next;
    logic [OFFSET_W-1:0]   off_reg, off_next;
    logic [WORD_W-1:0]     copy_reg, copy_next;
    logic [AW-1:0]         wp_reg, wp_next;
    logic [AW:0]           ww_reg, ww_next;
    status_t               stream_reg, stream_next;

    logic                  do_match;
    logic                  do_next;
    logic                  do_put;
    logic                  refused;
    logic [WORD_W-1:0]     match_len;
    logic [FLAG_CNT_W-1:0] pos_dec;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FLAG;
            flag_reg   <= '0;
            pos_reg    <= '0;
            off_reg    <= '0;
            copy_reg   <= '0;
            wp_reg     <= '0;
            ww_reg     <= '0;
            stream_reg <= ST_OK;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            flag_reg   <= flag_next;
            pos_reg    <= pos_next;
            off_reg    <= off_next;
            copy_reg   <= copy_next;
            wp_reg     <= wp_next;
            ww_reg     <= ww_next;
            stream_reg <= stream_next;
        end
    end

    // history source address of a copy and destination of any emitted word
    assign rd_addr = wp_reg - AW'(off_reg);
    assign wr_addr = wp_reg;

    // next state and result of one request
    always_comb
    begin
        phase_next  = phase_reg;
        flag_next   = flag_reg;
        pos_next    = pos_reg;
        off_next    = off_reg;
        copy_next   = copy_reg;
        wp_next     = wp_reg;
        ww_next     = ww_reg;
        stream_next = stream_reg;
        do_match    = 1'b0;
        do_next     = 1'b0;
        do_put      = 1'b0;
        refused     = 1'b0;
        match_len   = '0;
        item        = '0;

        case (op)
            OP_RESTART:
            begin
                phase_next  = PH_FLAG;
                flag_next   = '0;
                pos_next    = '0;
                off_next    = '0;
                copy_next   = '0;
                wp_next     = '0;
                ww_next     = '0;
                stream_next = ST_OK;
            end
            OP_PUSH:
            begin
                if (copy_reg != '0)
                begin
                    refused = 1'b1;
                end
                else if (stream_reg == ST_OK)
                begin
                    case (phase_reg)
                        PH_FLAG:
                        begin
                            flag_next  = word;
                            pos_next   = FLAG_ITEMS;
                            phase_next = PH_ITEM;
                        end
                        PH_ITEM:
                        begin
                            flag_next = {flag_reg[WORD_W-2:0], 1'b0};
                            if (!flag_reg[WORD_W-1])
                            begin
                                // literal word goes out on the push itself
                                do_put    = 1'b1;
                                do_next   = 1'b1;
                                item.emit = 1'b1;
                                item.data = word;
                            end
                            else
                            begin
                                off_next = word[OFFSET_W-1:0];
                                if (word[WORD_W-1:OFFSET_W] == '0)
                                begin
                                    phase_next = PH_LEN;
                                end
                                else
                                begin
                                    do_match  = 1'b1;
                                    match_len = WORD_W'(word[WORD_W-1:OFFSET_W]);
                                end
                            end
                        end
                        PH_LEN:
                        begin
                            do_match  = 1'b1;
                            match_len = word;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            OP_TICK:
            begin
                if (copy_reg != '0)
                begin
                    do_put       = 1'b1;
                    item.emit    = 1'b1;
                    item.src_mem = (off_reg != '0);
                    copy_next    = copy_reg - 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // match start: end marker, offset check, copy setup
        if (do_match)
        begin
            if (off_next == '0 && match_len == '0)
            begin
                stream_next = ST_END;
            end
            else if (off_next != '0 && AW1'(off_next) > ww_reg)
            begin
                stream_next = ST_BAD_OFFSET;
            end
            else
            begin
                copy_next = match_len;
                do_next   = 1'b1;
            end
        end

        // advance to the next item under the flag word
        pos_dec = (pos_reg != '0) ? pos_reg - 1'b1 : pos_reg;
        if (do_next)
        begin
            pos_next   = pos_dec;
            phase_next = (pos_dec == '0) ? PH_FLAG : PH_ITEM;
        end

        // window write pointer and saturating fill count
        if (do_put)
        begin
            wp_next = wp_reg + 1'b1;
            if (ww_reg != WW_FULL)
            begin
                ww_next = ww_reg + 1'b1;
            end
        end

        item.copy_pending = (copy_next != '0);
        item.status       = refused ? ST_REFUSED : stream_next;
    end

endmodule

// ----- design/lzwd_checker.sv -----
// ----------------------------------------------------------------------------
// lzwd_checker
// Port-level checks on the decompressor result channel, bound to the top.
// ----------------------------------------------------------------------------
module lzwd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no word when the valid flag is clear
    a_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[16:1] == 16'd0)
        else $error("word present without valid flag");

    // a refused push only happens with a copy still pending
    a_refused: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[19:18] == 2'd3 |-> m_tdata[17])
        else $error("push refused without pending copy");

    // words only come out of a running stream
    a_emit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[19:18] == 2'd0)
        else $error("word emitted with non-ok status");

    // input only stalls behind a stalled result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with result channel free");

endmodule

bind lz_word_decompressor lzwd_checker u_lzwd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
